FILE: src/rpm_pkg.sv
// ---------------------------------------------------------------------------
// rpm_pkg: shared types and constants for the RAM page type map
// Holds the operation codes, field widths, the beat structs passed between
// the top level and the map engine, and the engine state type.
// ---------------------------------------------------------------------------
`default_nettype none

package rpm_pkg;

  // Field widths of one input beat and one result beat.
  localparam int OP_W    = 2;
  localparam int PAGE_W  = 8;
  localparam int SIZE_W  = 19;
  localparam int TYPE_W  = 2;
  localparam int LIMIT_W = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_GET   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Reset value of the pages-in-use register.
  localparam logic [LIMIT_W-1:0] PAGES_RESET = 9'd256;

  typedef struct packed {
    logic [TYPE_W-1:0] new_type;
    logic [SIZE_W-1:0] size_bytes;
    logic [PAGE_W-1:0] page_index;
    logic [OP_W-1:0]   operation;
  } rpm_cmd_t;

  typedef struct packed {
    logic              page_invalid;
    logic [TYPE_W-1:0] page_type;
  } rpm_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_RD,
    ST_SET_RD,
    ST_SET_WALK,
    ST_CLEAR,
    ST_FINISH
  } rpm_state_t;

endpackage

`default_nettype wire

FILE: src/rpm_engine.sv
// ---------------------------------------------------------------------------
// rpm_engine: map storage and operation sequencer
// Keeps the two-bit page types in a synchronous word memory and runs get as a
// read, set as read-modify-write sequences and clear as a pass of zero writes, one command at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module rpm_engine #(
  parameter int MAX_PAGES  = 256,
  parameter int PAGE_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  rpm_pkg::rpm_cmd_t              cmd,
  input  logic [rpm_pkg::LIMIT_W-1:0]    limit,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rpm_pkg::rpm_res_t              res
);
  import rpm_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + 15) / 16;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [SIZE_W-1:0] PB        = SIZE_W'(PAGE_BYTES);
  localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);

  rpm_state_t state, state_next;

  // Map storage and its registered read port.
  logic [31:0]         mem [MAP_WORDS];
  logic [31:0]         rd_data;
  logic [AW-1:0]       mem_raddr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [31:0]         mem_wdata;

  // Command registers.
  logic [LIMIT_W-1:0]  page;
  logic [SIZE_W-1:0]   remaining;
  logic [TYPE_W-1:0]   ntype;
  logic [31:0]         word_buf;
  logic [AW-1:0]       clr_addr;
  logic                report;
  logic [TYPE_W-1:0]   ptype;
  logic                invalid;

  // Walk helpers.
  logic [LIMIT_W-1:0]  in_page;
  logic                in_below;
  logic [LIMIT_W-1:0]  page_next;
  logic [SIZE_W-1:0]   rem_next;
  logic                walk_more;
  logic                word_end;
  logic [31:0]         mod_word;

  assign in_page   = {1'b0, cmd.page_index};
  assign in_below  = in_page < limit;
  assign page_next = page + LIMIT_W'(1);
  assign rem_next  = (remaining > PB) ? (remaining - PB) : '0;
  assign walk_more = (rem_next != '0) && (page_next < limit);
  assign word_end  = (page_next[3:0] == 4'd0);

  // Current word with the type of the walking page replaced.
  always_comb begin
    mod_word = word_buf;
    mod_word[{page[3:0], 1'b0} +: TYPE_W] = ntype;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.operation)
            OP_GET:   state_next = in_below ? ST_GET_RD : ST_FINISH;
            OP_SET:   state_next = (cmd.size_bytes != '0 && in_below) ? ST_SET_RD
                                                                     : ST_FINISH;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_GET_RD: state_next = ST_FINISH;
      ST_SET_RD: state_next = ST_SET_WALK;
      ST_SET_WALK: begin
        if (!walk_more) begin
          state_next = ST_FINISH;
        end else if (word_end) begin
          state_next = ST_SET_RD;
        end
      end
      ST_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = report ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory control outputs.
  always_comb begin
    cmd_ready = 1'b0;
    res_valid = 1'b0;
    mem_raddr = AW'(page >> 4);
    mem_we    = 1'b0;
    mem_waddr = AW'(page >> 4);
    mem_wdata = mod_word;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        mem_raddr = AW'(cmd.page_index >> 4);
      end
      ST_SET_WALK: begin
        mem_raddr = AW'(page_next >> 4);
        mem_we    = !walk_more || word_end;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.page_type    = ptype;
  assign res.page_invalid = invalid;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Control state; reset starts a clearing pass that reports nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      report   <= 1'b0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_valid) begin
        report   <= 1'b1;
        clr_addr <= '0;
      end else if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Command payload and the walk through the set run.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          page      <= in_page;
          remaining <= cmd.size_bytes;
          ntype     <= cmd.new_type;
          ptype     <= '0;
          invalid   <= (cmd.operation == OP_GET) && !in_below;
        end
      end
      ST_GET_RD: ptype <= rd_data[{page[3:0], 1'b0} +: TYPE_W];
      ST_SET_RD: word_buf <= rd_data;
      ST_SET_WALK: begin
        word_buf  <= mod_word;
        page      <= page_next;
        remaining <= rem_next;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/ram_page_type_map.sv
// ---------------------------------------------------------------------------
// ram_page_type_map: two-bit usage type per RAM page
// Top level with the stream ports, the pages-in-use register and the result
// register in front of the map engine.
// ---------------------------------------------------------------------------
// The map holds a two-bit type for each page, sixteen pages to a 32-bit word
// in a single-port-write memory, and handles one command at a time. A get
// within the limit reads its map word before the result is ready. A get past
// the limit, an unused operation code and a set that writes nothing go
// straight to the result. A set walks the pages it writes, with one memory
// read per map word it touches. A clear writes one word per cycle. After
// reset the block runs the same word-per-cycle clearing pass before it takes
// its first beat. Results go to an output register, so a new command is
// taken while the last result is still waiting.
`default_nettype none

module ram_page_type_map #(
  parameter int MAX_PAGES  = 256,
  parameter int PAGE_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: pages in use.
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], page_index[9:2], size_bytes[28:10], new_type[30:29]
  input  logic [31:0] s_axis_tdata,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // page_type[1:0], page_invalid[2]
  output logic [7:0]  m_axis_tdata
);
  import rpm_pkg::*;

  localparam int LIMIT_CAP = (MAX_PAGES < 511) ? MAX_PAGES : 511;

  logic [LIMIT_W-1:0] pages_in_use;
  logic [LIMIT_W-1:0] limit;
  rpm_cmd_t           cmd;
  rpm_res_t           res;
  rpm_res_t           res_q;
  logic               res_valid;
  logic               res_ready;

  // Pages-in-use register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PAGES_RESET;
    end else if (cfg_we) begin
      pages_in_use <= cfg_wdata;
    end
  end

  // Page limit saturates at MAX_PAGES, and at 511 for larger maps.
  assign limit = (pages_in_use > LIMIT_W'(LIMIT_CAP)) ? LIMIT_W'(LIMIT_CAP) : pages_in_use;

  assign cmd = rpm_cmd_t'(s_axis_tdata[$bits(rpm_cmd_t)-1:0]);

  rpm_engine #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd       (cmd),
    .limit     (limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {5'd0, res_q};

endmodule

`default_nettype wire
